FILE: rtl/core/touch_coordinate_mapper_top_macros.svh
// Assertion macros for the touch coordinate mapper checker.
// Needs nothing else; included by the checker file.
`ifndef TOUCH_COORDINATE_MAPPER_TOP_MACROS_SVH
`define TOUCH_COORDINATE_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TCM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define TCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/tcm_pkg.sv
// Shared types and constants for the touch coordinate mapper.
// No dependencies; used by the top level and the checker.
package tcm_pkg;

   // Field widths
   localparam int RAW_W      = 16;
   localparam int DISP_X_W   = 10;
   localparam int DISP_Y_W   = 9;
   localparam int CSR_DATA_W = 16;

   // Default display size
   localparam int DISPLAY_WIDTH_DEF  = 800;
   localparam int DISPLAY_HEIGHT_DEF = 480;

   // Register reset values
   localparam logic [RAW_W-1:0] TOUCH_RES_X_RST = 16'd800;
   localparam logic [RAW_W-1:0] TOUCH_RES_Y_RST = 16'd480;

   // Register indexes
   typedef enum logic [2:0] {
      CSR_INVERT_X    = 3'd0,
      CSR_INVERT_Y    = 3'd1,
      CSR_SWAP_AXES   = 3'd2,
      CSR_FLIP_OUT_X  = 3'd3,
      CSR_FLIP_OUT_Y  = 3'd4,
      CSR_TOUCH_RES_X = 3'd5,
      CSR_TOUCH_RES_Y = 3'd6
   } csr_index_type;

   // Input point
   typedef struct packed {
      logic [RAW_W-1:0] raw_x;
      logic [RAW_W-1:0] raw_y;
      logic             point_valid;
   } req_payload_type;

   // Display coordinate
   typedef struct packed {
      logic [DISP_X_W-1:0] disp_x;
      logic [DISP_Y_W-1:0] disp_y;
   } rsp_payload_type;

endpackage

FILE: rtl/core/touch_coordinate_mapper_top.sv
// Touch coordinate mapper: orientation (mirror, swap, mirror) and scaling to display size.
// Depends on tcm_pkg.

// A new raw point may be transferred in every cycle while req_stall is low. Each point passes
// through three stages of mirroring, divisor selection and the constant multiply, then one
// restoring-division stage per quotient bit, QB = clog2(max(DISPLAY_WIDTH, DISPLAY_HEIGHT)) of
// them but at least 1, then the output register. The pipeline
// moves as one: while a result waits with rsp_stall high, req_stall is high and every stage holds.
// An invalid point gives zero on both axes. Configuration writes are taken in every cycle
// (csr_ready is always high) and must only be made while no point is in flight.
module touch_coordinate_mapper_top #(
   parameter int DISPLAY_WIDTH  = tcm_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = tcm_pkg::DISPLAY_HEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // point input
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tcm_pkg::req_payload_type req_payload,
   // result output
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tcm_pkg::rsp_payload_type rsp_payload,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  tcm_pkg::csr_index_type  csr_index,
   input  logic [tcm_pkg::CSR_DATA_W-1:0] csr_data
);
   import tcm_pkg::*;

   // Derived sizes
   localparam int MAX_SIZE = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
   localparam int SZW      = $clog2(MAX_SIZE + 1);
   localparam int QB_RAW   = $clog2(MAX_SIZE);
   localparam int QB       = (QB_RAW < 1) ? 1 : QB_RAW;
   localparam int NW       = RAW_W + SZW;
   localparam int DS       = QB;

   localparam logic [RAW_W-1:0]    WIDTH_DIV  = RAW_W'(DISPLAY_WIDTH);
   localparam logic [RAW_W-1:0]    HEIGHT_DIV = RAW_W'(DISPLAY_HEIGHT);
   localparam logic [DISP_X_W-1:0] X_MAX      = DISP_X_W'(DISPLAY_WIDTH - 1);
   localparam logic [DISP_Y_W-1:0] Y_MAX      = DISP_Y_W'(DISPLAY_HEIGHT - 1);

   // Mirror against a resolution; out-of-range values go to zero
   function automatic logic [RAW_W-1:0] mirror(input logic [RAW_W-1:0] v,
                                               input logic [RAW_W-1:0] res);
      if (v >= res) begin
         return '0;
      end
      return res - RAW_W'(1) - v;
   endfunction

   // Configuration registers
   logic             invert_x_ff, invert_y_ff, swap_axes_ff, flip_out_x_ff, flip_out_y_ff;
   logic [RAW_W-1:0] touch_res_x_ff, touch_res_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_x_ff    <= 1'b0;
         invert_y_ff    <= 1'b0;
         swap_axes_ff   <= 1'b0;
         flip_out_x_ff  <= 1'b0;
         flip_out_y_ff  <= 1'b0;
         touch_res_x_ff <= TOUCH_RES_X_RST;
         touch_res_y_ff <= TOUCH_RES_Y_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INVERT_X:    invert_x_ff    <= csr_data[0];
            CSR_INVERT_Y:    invert_y_ff    <= csr_data[0];
            CSR_SWAP_AXES:   swap_axes_ff   <= csr_data[0];
            CSR_FLIP_OUT_X:  flip_out_x_ff  <= csr_data[0];
            CSR_FLIP_OUT_Y:  flip_out_y_ff  <= csr_data[0];
            CSR_TOUCH_RES_X: touch_res_x_ff <= csr_data[RAW_W-1:0];
            CSR_TOUCH_RES_Y: touch_res_y_ff <= csr_data[RAW_W-1:0];
            default: ;
         endcase
      end
   end

   // Whole pipeline advances when the output register is free or being taken
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- stage 1: input mirror and swap ----------------
   logic             s1_valid_ff, s1_pv_ff;
   logic [RAW_W-1:0] s1_x_ff, s1_y_ff, s1_x_in, s1_y_in;
   logic [RAW_W-1:0] m_x, m_y;

   always_comb begin
      m_x     = invert_x_ff ? mirror(req_payload.raw_x, touch_res_x_ff) : req_payload.raw_x;
      m_y     = invert_y_ff ? mirror(req_payload.raw_y, touch_res_y_ff) : req_payload.raw_y;
      s1_x_in = swap_axes_ff ? m_y : m_x;
      s1_y_in = swap_axes_ff ? m_x : m_y;
   end

   // ---------------- stage 2: output mirror and divisor ----------------
   logic             s2_valid_ff, s2_pv_ff;
   logic [RAW_W-1:0] s2_x_ff, s2_y_ff, s2_dx_ff, s2_dy_ff;
   logic [RAW_W-1:0] s2_x_in, s2_y_in, s2_dx_in, s2_dy_in;
   logic [RAW_W-1:0] src_res_x, src_res_y;

   always_comb begin
      s2_x_in   = flip_out_x_ff ? mirror(s1_x_ff, touch_res_x_ff) : s1_x_ff;
      s2_y_in   = flip_out_y_ff ? mirror(s1_y_ff, touch_res_y_ff) : s1_y_ff;
      src_res_x = swap_axes_ff ? touch_res_y_ff : touch_res_x_ff;
      src_res_y = swap_axes_ff ? touch_res_x_ff : touch_res_y_ff;
      // zero resolution divides by the display size
      s2_dx_in  = (src_res_x == '0) ? WIDTH_DIV : src_res_x;
      s2_dy_in  = (src_res_y == '0) ? HEIGHT_DIV : src_res_y;
   end

   // ---------------- stage 3: numerator and clamp decision ----------------
   // v * size / d reaches size exactly when v >= d, so the clamp is known here
   logic             s3_valid_ff, s3_pv_ff, s3_clx_ff, s3_cly_ff;
   logic [NW-1:0]    s3_nx_ff, s3_ny_ff, s3_nx_in, s3_ny_in;
   logic [RAW_W-1:0] s3_dx_ff, s3_dy_ff;

   assign s3_nx_in = NW'(s2_x_ff) * NW'(DISPLAY_WIDTH);
   assign s3_ny_in = NW'(s2_y_ff) * NW'(DISPLAY_HEIGHT);

   // ---------------- divider stages: one quotient bit each ----------------
   logic             dv_valid_ff [DS];
   logic             dv_pv_ff    [DS];
   logic             dv_clx_ff   [DS];
   logic             dv_cly_ff   [DS];
   logic [NW-1:0]    dv_nx_ff    [DS];
   logic [NW-1:0]    dv_ny_ff    [DS];
   logic [RAW_W-1:0] dv_dx_ff    [DS];
   logic [RAW_W-1:0] dv_dy_ff    [DS];
   logic [RAW_W-1:0] dv_rx_ff    [DS];
   logic [RAW_W-1:0] dv_ry_ff    [DS];
   logic [QB-1:0]    dv_qx_ff    [DS];
   logic [QB-1:0]    dv_qy_ff    [DS];
   logic [RAW_W-1:0] dv_rx_in    [DS];
   logic [RAW_W-1:0] dv_ry_in    [DS];
   logic [QB-1:0]    dv_qx_in    [DS];
   logic [QB-1:0]    dv_qy_in    [DS];

   always_comb begin
      logic [NW-1:0]    src_nx, src_ny;
      logic [RAW_W-1:0] src_dx, src_dy, src_rx, src_ry;
      logic [QB-1:0]    src_qx, src_qy;
      logic [RAW_W:0]   sh_x, sh_y;
      for (int j = 0; j < DS; j++) begin
         if (j == 0) begin
            // the quotient fits in QB bits, so the top of the numerator is below d
            src_nx = s3_nx_ff;
            src_ny = s3_ny_ff;
            src_dx = s3_dx_ff;
            src_dy = s3_dy_ff;
            src_rx = s3_nx_ff[QB+RAW_W-1:QB];
            src_ry = s3_ny_ff[QB+RAW_W-1:QB];
            src_qx = '0;
            src_qy = '0;
         end else begin
            src_nx = dv_nx_ff[j-1];
            src_ny = dv_ny_ff[j-1];
            src_dx = dv_dx_ff[j-1];
            src_dy = dv_dy_ff[j-1];
            src_rx = dv_rx_ff[j-1];
            src_ry = dv_ry_ff[j-1];
            src_qx = dv_qx_ff[j-1];
            src_qy = dv_qy_ff[j-1];
         end
         sh_x        = {src_rx, src_nx[QB-1-j]};
         sh_y        = {src_ry, src_ny[QB-1-j]};
         dv_qx_in[j] = src_qx;
         dv_qy_in[j] = src_qy;
         if (sh_x >= {1'b0, src_dx}) begin
            dv_rx_in[j]         = RAW_W'(sh_x - {1'b0, src_dx});
            dv_qx_in[j][QB-1-j] = 1'b1;
         end else begin
            dv_rx_in[j] = sh_x[RAW_W-1:0];
         end
         if (sh_y >= {1'b0, src_dy}) begin
            dv_ry_in[j]         = RAW_W'(sh_y - {1'b0, src_dy});
            dv_qy_in[j][QB-1-j] = 1'b1;
         end else begin
            dv_ry_in[j] = sh_y[RAW_W-1:0];
         end
      end
   end

   // ---------------- output stage: invalid point, clamp, field mask ----------------
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   always_comb begin
      if (!dv_pv_ff[DS-1]) begin
         rsp_payload_in.disp_x = '0;
      end else if (dv_clx_ff[DS-1]) begin
         rsp_payload_in.disp_x = X_MAX;
      end else begin
         rsp_payload_in.disp_x = DISP_X_W'({{DISP_X_W{1'b0}}, dv_qx_ff[DS-1]});
      end
      if (!dv_pv_ff[DS-1]) begin
         rsp_payload_in.disp_y = '0;
      end else if (dv_cly_ff[DS-1]) begin
         rsp_payload_in.disp_y = Y_MAX;
      end else begin
         rsp_payload_in.disp_y = DISP_Y_W'({{DISP_Y_W{1'b0}}, dv_qy_ff[DS-1]});
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Valid bits of every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < DS; j++) begin
            dv_valid_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         s1_valid_ff    <= req_valid;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         dv_valid_ff[0] <= s3_valid_ff;
         for (int j = 1; j < DS; j++) begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
         rsp_valid_ff   <= dv_valid_ff[DS-1];
      end
   end

   // Payload of every stage
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pv_ff  <= req_payload.point_valid;
         s1_x_ff   <= s1_x_in;
         s1_y_ff   <= s1_y_in;

         s2_pv_ff  <= s1_pv_ff;
         s2_x_ff   <= s2_x_in;
         s2_y_ff   <= s2_y_in;
         s2_dx_ff  <= s2_dx_in;
         s2_dy_ff  <= s2_dy_in;

         s3_pv_ff  <= s2_pv_ff;
         s3_nx_ff  <= s3_nx_in;
         s3_ny_ff  <= s3_ny_in;
         s3_dx_ff  <= s2_dx_ff;
         s3_dy_ff  <= s2_dy_ff;
         s3_clx_ff <= s2_x_ff >= s2_dx_ff;
         s3_cly_ff <= s2_y_ff >= s2_dy_ff;

         for (int j = 0; j < DS; j++) begin
            if (j == 0) begin
               dv_pv_ff[j]  <= s3_pv_ff;
               dv_clx_ff[j] <= s3_clx_ff;
               dv_cly_ff[j] <= s3_cly_ff;
               dv_nx_ff[j]  <= s3_nx_ff;
               dv_ny_ff[j]  <= s3_ny_ff;
               dv_dx_ff[j]  <= s3_dx_ff;
               dv_dy_ff[j]  <= s3_dy_ff;
            end else begin
               dv_pv_ff[j]  <= dv_pv_ff[j-1];
               dv_clx_ff[j] <= dv_clx_ff[j-1];
               dv_cly_ff[j] <= dv_cly_ff[j-1];
               dv_nx_ff[j]  <= dv_nx_ff[j-1];
               dv_ny_ff[j]  <= dv_ny_ff[j-1];
               dv_dx_ff[j]  <= dv_dx_ff[j-1];
               dv_dy_ff[j]  <= dv_dy_ff[j-1];
            end
            dv_rx_ff[j] <= dv_rx_in[j];
            dv_ry_ff[j] <= dv_ry_in[j];
            dv_qx_ff[j] <= dv_qx_in[j];
            dv_qy_ff[j] <= dv_qy_in[j];
         end

         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

FILE: rtl/core/tcm_checker.sv
// Port-level checks for the touch coordinate mapper, bound to the top level.
// Depends on tcm_pkg and touch_coordinate_mapper_top_macros.svh.
`include "touch_coordinate_mapper_top_macros.svh"

module tcm_checker #(
   parameter int DISPLAY_WIDTH  = tcm_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = tcm_pkg::DISPLAY_HEIGHT_DEF
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input tcm_pkg::rsp_payload_type rsp_payload
);
   import tcm_pkg::*;

   // A waiting result holds until its transfer
   `TCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // With the output register empty the input is never held off
   `TCM_ASSERT_NOW(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall, "input stalled with empty output")

   // A held result freezes the pipeline, so the input must stall
   `TCM_ASSERT_NOW(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall || !req_valid, "input taken while result held")

   // Coordinates stay inside the display where the field can show it
   `TCM_ASSERT_NOW(a_x_range, clock, reset, rsp_valid, (DISPLAY_WIDTH > (1 << DISP_X_W)) || (rsp_payload.disp_x < DISPLAY_WIDTH), "disp_x beyond display width")
   `TCM_ASSERT_NOW(a_y_range, clock, reset, rsp_valid, (DISPLAY_HEIGHT > (1 << DISP_Y_W)) || (rsp_payload.disp_y < DISPLAY_HEIGHT), "disp_y beyond display height")

endmodule

bind touch_coordinate_mapper_top tcm_checker #(
   .DISPLAY_WIDTH  (DISPLAY_WIDTH),
   .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
) u_tcm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

FILE: sim/touch_coordinate_mapper_top_tb.sv
// Self-checking testbench for the touch coordinate mapper (orientation and scaling).
// Depends on tcm_pkg and touch_coordinate_mapper_top; predicts each display point
// and checks every result transfer in order.
module touch_coordinate_mapper_top_tb;
   import tcm_pkg::*;

   localparam int DISP_W        = DISPLAY_WIDTH_DEF;
   localparam int DISP_H        = DISPLAY_HEIGHT_DEF;
   localparam int PIPE_LATENCY  = $clog2((DISP_W > DISP_H) ? DISP_W : DISP_H) + 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 15;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_POINTS  = 100;
   localparam logic [2:0] CSR_SPARE_INDEX = 3'd7;
   localparam logic [RAW_W-1:0] RAW_MAX = '1;

   // DUT ports; the driven inputs are known from time zero
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index   = CSR_INVERT_X;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   // Predictor copy of the register set
   logic                  cfg_invert_x;
   logic                  cfg_invert_y;
   logic                  cfg_swap;
   logic                  cfg_flip_x;
   logic                  cfg_flip_y;
   logic [RAW_W-1:0]      cfg_res_x;
   logic [RAW_W-1:0]      cfg_res_y;

   rsp_payload_type       expected_points[$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   bit                    quiet_mode  = 1'b0;

   touch_coordinate_mapper_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run-length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !quiet_mode && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // ---------------------------------------------------------------- predictor

   // Mirror against a resolution; anything at or above it folds to zero
   function automatic logic [31:0] mirror_axis(logic [31:0] v, logic [31:0] res);
      return (v >= res) ? 32'd0 : res - 32'd1 - v;
   endfunction

   // Floor scale to the display size, zero resolution falls back to the size
   function automatic logic [31:0] scale_axis(logic [31:0] v, logic [31:0] res,
                                              logic [31:0] size);
      logic [31:0] divisor;
      logic [31:0] q;
      divisor = (res == 0) ? size : res;
      if (divisor == 0) divisor = 1;
      q = (v * size) / divisor;
      if (q >= size) q = (size == 0) ? 32'd0 : size - 32'd1;
      return q;
   endfunction

   function automatic rsp_payload_type map_point(req_payload_type p);
      logic [31:0]     x;
      logic [31:0]     y;
      logic [31:0]     t;
      logic [31:0]     sx;
      logic [31:0]     sy;
      rsp_payload_type r;
      r = '0;
      if (p.point_valid) begin
         x = 32'(p.raw_x);
         y = 32'(p.raw_y);
         if (cfg_invert_x) x = mirror_axis(x, 32'(cfg_res_x));
         if (cfg_invert_y) y = mirror_axis(y, 32'(cfg_res_y));
         if (cfg_swap) begin
            t = x;
            x = y;
            y = t;
         end
         // second mirror keeps the unswapped resolution of each axis name
         if (cfg_flip_x) x = mirror_axis(x, 32'(cfg_res_x));
         if (cfg_flip_y) y = mirror_axis(y, 32'(cfg_res_y));
         sx = scale_axis(x, 32'(cfg_swap ? cfg_res_y : cfg_res_x), DISP_W);
         sy = scale_axis(y, 32'(cfg_swap ? cfg_res_x : cfg_res_y), DISP_H);
         r.disp_x = sx[DISP_X_W-1:0];
         r.disp_y = sy[DISP_Y_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Compare each result transfer with the oldest expected point
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report_error($sformatf("unexpected result x=%0d y=%0d",
                                   rsp_payload.disp_x, rsp_payload.disp_y));
         end else begin
            want = expected_points.pop_front();
            if (rsp_payload.disp_x !== want.disp_x)
               report_error($sformatf("disp_x expected %0d got %0d",
                                      want.disp_x, rsp_payload.disp_x));
            if (rsp_payload.disp_y !== want.disp_y)
               report_error($sformatf("disp_y expected %0d got %0d",
                                      want.disp_y, rsp_payload.disp_y));
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   function automatic req_payload_type make_point(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y,
                                                  logic v);
      req_payload_type p;
      p.raw_x       = x;
      p.raw_y       = y;
      p.point_valid = v;
      return p;
   endfunction

   // One point transfer, with random idle cycles ahead of it
   task automatic send_point(input req_payload_type p);
      while (!quiet_mode && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      expected_points.push_back(map_point(p));
   endtask

   // Hold the sender off until every expected point has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
   endtask

   // One register write transfer; valid is left high for back-to-back writes
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INVERT_X:    cfg_invert_x = data[0];
         CSR_INVERT_Y:    cfg_invert_y = data[0];
         CSR_SWAP_AXES:   cfg_swap     = data[0];
         CSR_FLIP_OUT_X:  cfg_flip_x   = data[0];
         CSR_FLIP_OUT_Y:  cfg_flip_y   = data[0];
         CSR_TOUCH_RES_X: cfg_res_x    = data;
         CSR_TOUCH_RES_Y: cfg_res_y    = data;
         default: ;
      endcase
   endtask

   // Flag writes carry random upper bits that must be ignored
   function automatic logic [CSR_DATA_W-1:0] flag_word(logic f);
      logic [CSR_DATA_W-1:0] w;
      w    = CSR_DATA_W'($urandom);
      w[0] = f;
      return w;
   endfunction

   // Full register set, written only once the pipeline is empty
   task automatic set_config(input logic inv_x, input logic inv_y, input logic swap,
                             input logic flip_x, input logic flip_y,
                             input logic [RAW_W-1:0] res_x, input logic [RAW_W-1:0] res_y);
      drain_results();
      write_csr(CSR_INVERT_X,    flag_word(inv_x));
      write_csr(CSR_INVERT_Y,    flag_word(inv_y));
      write_csr(CSR_SWAP_AXES,   flag_word(swap));
      write_csr(CSR_FLIP_OUT_X,  flag_word(flip_x));
      write_csr(CSR_FLIP_OUT_Y,  flag_word(flip_y));
      write_csr(CSR_TOUCH_RES_X, res_x);
      write_csr(CSR_TOUCH_RES_Y, res_y);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // Reset values: plain scaling, clamp and invalid points
   task automatic test_reset_defaults();
      send_point(make_point(16'd0, 16'd0, 1'b1));
      send_point(make_point(16'd799, 16'd479, 1'b1));
      send_point(make_point(16'd800, 16'd480, 1'b1));
      send_point(make_point(RAW_MAX, RAW_MAX, 1'b1));
      send_point(make_point(RAW_MAX, RAW_MAX, 1'b0));
   endtask

   // First and second mirrors, at and beyond the resolution
   task automatic test_mirrors();
      set_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd800, 16'd480);
      send_point(make_point(16'd0, 16'd0, 1'b1));
      send_point(make_point(16'd799, 16'd479, 1'b1));
      send_point(make_point(16'd800, 16'd480, 1'b1));
      send_point(make_point(RAW_MAX, 16'd100, 1'b1));
      set_config(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd1000, 16'd300);
      send_point(make_point(16'd10, 16'd20, 1'b1));
      send_point(make_point(16'd999, 16'd300, 1'b1));
   endtask

   // Axis exchange, alone and with every mirror
   task automatic test_swap();
      set_config(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1024, 16'd600);
      send_point(make_point(16'd300, 16'd1000, 1'b1));
      send_point(make_point(16'd599, 16'd0, 1'b1));
      set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd1024, 16'd600);
      send_point(make_point(16'd300, 16'd1000, 1'b1));
      send_point(make_point(16'd1023, 16'd599, 1'b1));
   endtask

   // Zero, unit and maximum resolutions
   task automatic test_resolution_extremes();
      set_config(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0);
      send_point(make_point(16'd5, 16'd479, 1'b1));
      send_point(make_point(RAW_MAX, RAW_MAX, 1'b1));
      set_config(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 16'd1, 16'd1);
      send_point(make_point(16'd0, 16'd0, 1'b1));
      send_point(make_point(16'd1, 16'd0, 1'b1));
      set_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, RAW_MAX, RAW_MAX);
      send_point(make_point(16'd0, RAW_MAX, 1'b1));
      send_point(make_point(16'hFFFE, 16'd1, 1'b1));
   endtask

   // A write to an unused index leaves the register set alone
   task automatic test_spare_index();
      drain_results();
      write_csr(csr_index_type'(CSR_SPARE_INDEX), 16'hFFFF);
      csr_valid <= 1'b0;
      send_point(make_point(16'h1234, 16'h00FF, 1'b1));
   endtask

   function automatic logic [RAW_W-1:0] pick_resolution();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 16'd1;
         2:       return RAW_MAX;
         3:       return 16'd800;
         4:       return 16'd480;
         5:       return RAW_W'($urandom_range(2, 2000));
         default: return RAW_W'($urandom);
      endcase
   endfunction

   // Coordinates clustered around the resolution, with some full-range noise
   function automatic logic [RAW_W-1:0] pick_coord(logic [RAW_W-1:0] res);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return (res == 0) ? '0 : res - 1'b1;
         2:       return res;
         3:       return RAW_MAX;
         4, 5:    return (res == 0) ? '0 : RAW_W'($urandom_range(0, res - 1));
         default: return RAW_W'($urandom);
      endcase
   endfunction

   // Random register sets and points; one phase runs without idling
   task automatic test_random();
      req_payload_type p;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_config(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    pick_resolution(), pick_resolution());
         quiet_mode = (ph == 3);
         for (int n = 0; n < PHASE_POINTS; n++) begin
            // mid-phase hold-off until the pipeline is empty
            if (ph == 1 && n == PHASE_POINTS / 2) drain_results();
            p = make_point(pick_coord(cfg_res_x), pick_coord(cfg_res_y),
                           $urandom_range(0, 9) != 0);
            send_point(p);
         end
         quiet_mode = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      cfg_invert_x = 1'b0;
      cfg_invert_y = 1'b0;
      cfg_swap     = 1'b0;
      cfg_flip_x   = 1'b0;
      cfg_flip_y   = 1'b0;
      cfg_res_x    = TOUCH_RES_X_RST;
      cfg_res_y    = TOUCH_RES_Y_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_mirrors();
      test_swap();
      test_resolution_extremes();
      test_spare_index();
      test_random();

      drain_results();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
